// File: hw/rtl/asgd_pkg.sv
// Shared types and constants for the optimizer weight update block.
`timescale 1ns / 1ps
package asgd_pkg;

    localparam int NUM_PARAMS = 4096;
    localparam int IDX_W      = $clog2(NUM_PARAMS);
    localparam int DATA_W     = 32;
    localparam int DIV_W      = 96;
    localparam int DEN_W      = 57;
    localparam int CNT_W      = 7;
    localparam int SQ_ARG_W   = 64;
    localparam int SQ_REM_W   = 35;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_LR      = 3'd1,
        CFG_BETA1   = 3'd2,
        CFG_BETA2   = 3'd3,
        CFG_EPSILON = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_GDIV, S_SGD_MUL, S_SGD_FIN, S_LATCH_G,
        S_POW1, S_POW2, S_POW_FIN, S_MUL_BM, S_MUL_CG, S_MUL_GG, S_MUL_BV,
        S_MUL_CH, S_MUL_CL, S_VSUM, S_VCLIP, S_MHDIV, S_VH_LD, S_VHDIV,
        S_SQ_LD, S_SQRT, S_MUL_LL, S_MUL_LH, S_ST_LD, S_STDIV, S_STEP, S_RESULT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_SGD_MUL, OP_SGD_FIN, OP_LATCH_G,
        OP_POW1, OP_POW2, OP_POW_FIN, OP_MUL_BM, OP_MUL_CG, OP_MUL_GG, OP_MUL_BV,
        OP_MUL_CH, OP_MUL_CL, OP_VSUM, OP_VCLIP, OP_VH_LD, OP_SQ_LD, OP_MUL_LL,
        OP_MUL_LH, OP_ST_LD, OP_STEP, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic sqrt_busy;
        logic adam;
        logic new_pass;
    } t_status;

endpackage

// File: hw/rtl/adam_sgd_weight_update.sv
// Result timing is set by the shared bit-serial divider (32, 64, 64 and 96 steps; SGD
// uses only the first) and, in Adam mode, the 32-step root unit. One item is in work at a
// time; the next transfer can be taken no earlier than the cycle after the result loads.
// A result waits in an output register while the next item is taken. Reset (synchronous,
// active low) restores config and powers, then clears all 4096 entries of both moment stores.
`timescale 1ns / 1ps
module adam_sgd_weight_update import asgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // param_index[11:0], weight_in[43:12], grad_sum[75:44], sample_count[91:76], zero pad
    input  logic [95:0]          i_s_axis_tdata,
    // new_pass[0]
    input  logic [0:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // weight_out[31:0]
    output logic [DATA_W-1:0]    o_m_axis_tdata,
    // saturated[0]
    output logic [0:0]           o_m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    asgd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    asgd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

endmodule

// File: hw/rtl/asgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module asgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/asgd_ctrl.sv
// Sequencer for the optimizer update: steps the datapath through each item.
`timescale 1ns / 1ps
module asgd_ctrl import asgd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    output logic    o_m_axis_tvalid,
    input  logic    i_m_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_status.clr_last) n_state = S_IDLE;
            S_IDLE:    if (i_s_axis_tvalid) n_state = S_GDIV;
            S_GDIV: begin
                if (!i_status.div_busy) n_state = i_status.adam ? S_LATCH_G : S_SGD_MUL;
            end
            S_SGD_MUL: n_state = S_SGD_FIN;
            S_SGD_FIN: n_state = S_RESULT;
            S_LATCH_G: n_state = i_status.new_pass ? S_POW1 : S_MUL_BM;
            S_POW1:    n_state = S_POW2;
            S_POW2:    n_state = S_POW_FIN;
            S_POW_FIN: n_state = S_MUL_BM;
            S_MUL_BM:  n_state = S_MUL_CG;
            S_MUL_CG:  n_state = S_MUL_GG;
            S_MUL_GG:  n_state = S_MUL_BV;
            S_MUL_BV:  n_state = S_MUL_CH;
            S_MUL_CH:  n_state = S_MUL_CL;
            S_MUL_CL:  n_state = S_VSUM;
            S_VSUM:    n_state = S_VCLIP;
            S_VCLIP:   n_state = S_MHDIV;
            S_MHDIV:   if (!i_status.div_busy) n_state = S_VH_LD;
            S_VH_LD:   n_state = S_VHDIV;
            S_VHDIV:   if (!i_status.div_busy) n_state = S_SQ_LD;
            S_SQ_LD:   n_state = S_SQRT;
            S_SQRT:    if (!i_status.sqrt_busy) n_state = S_MUL_LL;
            S_MUL_LL:  n_state = S_MUL_LH;
            S_MUL_LH:  n_state = S_ST_LD;
            S_ST_LD:   n_state = S_STDIV;
            S_STDIV:   if (!i_status.div_busy) n_state = S_STEP;
            S_STEP:    n_state = S_RESULT;
            S_RESULT:  if (out_free) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NONE;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        unique case (r_state)
            S_CLEAR:   o_cmd.op = OP_CLEAR;
            S_IDLE:    if (i_s_axis_tvalid) o_cmd.op = OP_ACCEPT;
            S_SGD_MUL: o_cmd.op = OP_SGD_MUL;
            S_SGD_FIN: o_cmd.op = OP_SGD_FIN;
            S_LATCH_G: o_cmd.op = OP_LATCH_G;
            S_POW1:    o_cmd.op = OP_POW1;
            S_POW2:    o_cmd.op = OP_POW2;
            S_POW_FIN: o_cmd.op = OP_POW_FIN;
            S_MUL_BM:  o_cmd.op = OP_MUL_BM;
            S_MUL_CG:  o_cmd.op = OP_MUL_CG;
            S_MUL_GG:  o_cmd.op = OP_MUL_GG;
            S_MUL_BV:  o_cmd.op = OP_MUL_BV;
            S_MUL_CH:  o_cmd.op = OP_MUL_CH;
            S_MUL_CL:  o_cmd.op = OP_MUL_CL;
            S_VSUM:    o_cmd.op = OP_VSUM;
            S_VCLIP:   o_cmd.op = OP_VCLIP;
            S_VH_LD:   o_cmd.op = OP_VH_LD;
            S_SQ_LD:   o_cmd.op = OP_SQ_LD;
            S_MUL_LL:  o_cmd.op = OP_MUL_LL;
            S_MUL_LH:  o_cmd.op = OP_MUL_LH;
            S_ST_LD:   o_cmd.op = OP_ST_LD;
            S_STEP:    o_cmd.op = OP_STEP;
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.op    = OP_RESULT;
                    n_out_valid = 1'b1;
                end
            end
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;

endmodule

// File: hw/rtl/asgd_dp.sv
// Datapath: config registers, moment stores, shared multiplier, divider and square root.
`timescale 1ns / 1ps
module asgd_dp import asgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [95:0]          i_s_axis_tdata,
    input  logic [0:0]           i_s_axis_tuser,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output logic [DATA_W-1:0]    o_m_axis_tdata,
    output logic [0:0]           o_m_axis_tuser
);

    localparam logic [32:0] ONE33   = 33'h1_0000_0000;
    localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

    // configuration and running powers
    logic              r_adam;
    logic [31:0]       r_lr, r_b1, r_b2, r_eps, r_p1, r_p2;

    // item registers
    logic [IDX_W-1:0]  r_idx, r_clr_addr;
    logic [31:0]       r_w, r_gmag, r_m, r_v;
    logic              r_gsign, r_np, r_vsat, r_big, r_neg;
    logic [67:0]       r_acc;
    logic [47:0]       r_gsq;
    logic [48:0]       r_accv;
    logic [63:0]       r_mhat;
    logic [DEN_W-1:0]  r_den;
    logic [40:0]       r_step;
    logic [31:0]       r_out_w;
    logic              r_out_sat;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] r_prod;

    // shared divider: quotient shifts into the low end of the dividend register
    logic [DIV_W-1:0]   r_dreg, div_dividend;
    logic [DEN_W-1:0]   r_dsor, div_divisor;
    logic [DEN_W-1:0]   r_drem;
    logic [CNT_W-1:0]   r_dcnt, div_n;
    logic               div_load;
    logic [DEN_W:0]     drem_sh;
    logic               dfit;

    // square root
    logic [SQ_ARG_W-1:0] r_sq_arg, sq_arg;
    logic [SQ_REM_W-1:0] r_sq_rem, sq_rem_sh, sq_trial;
    logic [31:0]         r_sq_root;
    logic [5:0]          r_sq_cnt;
    logic                sq_load;

    // moment stores
    logic [IDX_W-1:0]  ram_raddr, ram_waddr;
    logic              ram_we;
    logic [31:0]       m_wdata, v_wdata, m_rdata, v_rdata;

    logic [31:0]       in_grad, grad_mag;
    logic [15:0]       in_cnt;
    logic signed [33:0] g_signed;
    logic [67:0]       m_sum;
    logic [31:0]       m_mag;
    logic [63:0]       vhat;
    logic [39:0]       root_full;
    logic [DEN_W-1:0]  den_raw;
    logic [95:0]       prod96;
    logic [48:0]       vsum;
    logic signed [42:0] res_full;
    logic [31:0]       v_clip;
    logic              v_over;

    assign in_grad  = i_s_axis_tdata[75:44];
    assign in_cnt   = i_s_axis_tdata[91:76];
    assign grad_mag = in_grad[31] ? (32'd0 - in_grad) : in_grad;
    assign g_signed = r_gsign ? (34'sd0 - $signed({2'b00, r_gmag}))
                              : $signed({2'b00, r_gmag});
    assign m_sum    = r_acc + r_prod;
    assign m_mag    = r_m[31] ? (32'd0 - r_m) : r_m;
    assign vhat     = r_dreg[63:0];
    assign root_full = r_big ? {r_sq_root, 8'd0} : {8'd0, r_sq_root};
    assign den_raw  = {1'b0, root_full, 16'd0} + {25'd0, r_eps};
    assign prod96   = {32'd0, r_acc[63:0]} + {r_prod[63:0], 32'd0};
    assign vsum     = r_accv;
    assign v_over   = (vsum[48:31] != 18'd0);
    assign v_clip   = v_over ? 32'h7FFF_FFFF : vsum[31:0];

    // operand selection for the multiplier, divider and root
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_load     = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        div_n        = '0;
        sq_load      = 1'b0;
        sq_arg       = '0;
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                div_load     = 1'b1;
                div_dividend = {grad_mag, 64'd0};
                div_divisor  = {41'd0, (in_cnt == 16'd0) ? 16'd1 : in_cnt};
                div_n        = CNT_W'(32);
            end
            OP_SGD_MUL: begin
                mul_a = $signed({2'b00, r_lr});
                mul_b = $signed({2'b00, r_dreg[31:0]});
            end
            OP_POW1: begin
                mul_a = $signed({2'b00, r_p1});
                mul_b = $signed({2'b00, r_b1});
            end
            OP_POW2: begin
                mul_a = $signed({2'b00, r_p2});
                mul_b = $signed({2'b00, r_b2});
            end
            OP_MUL_BM: begin
                mul_a = $signed({2'b00, r_b1});
                mul_b = $signed({{2{m_rdata[31]}}, m_rdata});
            end
            OP_MUL_CG: begin
                mul_a = $signed({1'b0, ONE33 - {1'b0, r_b1}});
                mul_b = g_signed;
            end
            OP_MUL_GG: begin
                mul_a = $signed({2'b00, r_gmag});
                mul_b = $signed({2'b00, r_gmag});
            end
            OP_MUL_BV: begin
                mul_a = $signed({2'b00, r_b2});
                mul_b = $signed({2'b00, v_rdata});
            end
            OP_MUL_CH: begin
                mul_a = $signed({1'b0, ONE33 - {1'b0, r_b2}});
                mul_b = $signed({18'd0, r_gsq[47:32]});
            end
            OP_MUL_CL: begin
                mul_a = $signed({1'b0, ONE33 - {1'b0, r_b2}});
                mul_b = $signed({2'b00, r_gsq[31:0]});
            end
            OP_VCLIP: begin
                div_load     = 1'b1;
                div_dividend = {m_mag, 64'd0};
                div_divisor  = {24'd0, ONE33 - {1'b0, r_p1}};
                div_n        = CNT_W'(64);
            end
            OP_VH_LD: begin
                div_load     = 1'b1;
                div_dividend = {r_v, 64'd0};
                div_divisor  = {24'd0, ONE33 - {1'b0, r_p2}};
                div_n        = CNT_W'(64);
            end
            OP_SQ_LD: begin
                sq_load = 1'b1;
                sq_arg  = (vhat[63:48] == 16'd0) ? {vhat[47:0], 16'd0} : vhat;
            end
            OP_MUL_LL: begin
                mul_a = $signed({2'b00, r_lr});
                mul_b = $signed({2'b00, r_mhat[31:0]});
            end
            OP_MUL_LH: begin
                mul_a = $signed({2'b00, r_lr});
                mul_b = $signed({2'b00, r_mhat[63:32]});
            end
            OP_ST_LD: begin
                div_load     = 1'b1;
                div_dividend = prod96;
                div_divisor  = r_den;
                div_n        = CNT_W'(96);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // restoring division, one quotient bit a cycle
    assign drem_sh = {r_drem, r_dreg[DIV_W-1]};
    assign dfit    = (drem_sh >= {1'b0, r_dsor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (div_load) begin
            r_dcnt <= div_n;
            r_dreg <= div_dividend;
            r_dsor <= div_divisor;
            r_drem <= '0;
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - CNT_W'(1);
            r_dreg <= {r_dreg[DIV_W-2:0], dfit};
            r_drem <= dfit ? DEN_W'(drem_sh - {1'b0, r_dsor}) : drem_sh[DEN_W-1:0];
        end
    end

    // integer square root, two argument bits a cycle
    assign sq_rem_sh = {r_sq_rem[SQ_REM_W-3:0], r_sq_arg[SQ_ARG_W-1 -: 2]};
    assign sq_trial  = {1'b0, r_sq_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (sq_load) begin
            r_sq_cnt  <= 6'd32;
            r_sq_arg  <= sq_arg;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_cnt != '0) begin
            r_sq_cnt <= r_sq_cnt - 6'd1;
            r_sq_arg <= {r_sq_arg[SQ_ARG_W-3:0], 2'b00};
            if (sq_rem_sh >= sq_trial) begin
                r_sq_rem  <= sq_rem_sh - sq_trial;
                r_sq_root <= {r_sq_root[30:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_rem_sh;
                r_sq_root <= {r_sq_root[30:0], 1'b0};
            end
        end
    end

    assign ram_raddr = (i_cmd.op == OP_ACCEPT) ? i_s_axis_tdata[IDX_W-1:0] : r_idx;
    assign ram_we    = (i_cmd.op == OP_CLEAR) || (i_cmd.op == OP_VCLIP);
    assign ram_waddr = (i_cmd.op == OP_CLEAR) ? r_clr_addr : r_idx;
    assign m_wdata   = (i_cmd.op == OP_CLEAR) ? 32'd0 : r_m;
    assign v_wdata   = (i_cmd.op == OP_CLEAR) ? 32'd0 : v_clip;

    asgd_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_m_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (m_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (m_rdata)
    );

    asgd_ram #(.WIDTH(32), .DEPTH(NUM_PARAMS)) u_v_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (v_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (v_rdata)
    );

    assign res_full = r_neg ? ($signed({{11{r_w[31]}}, r_w}) + $signed({2'b00, r_step}))
                            : ($signed({{11{r_w[31]}}, r_w}) - $signed({2'b00, r_step}));

    // control state: config, powers, clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adam     <= 1'b0;
            r_lr       <= 32'd42950;
            r_b1       <= 32'd3865470566;
            r_b2       <= 32'd4290672329;
            r_eps      <= 32'd43;
            r_p1       <= 32'hFFFF_FFFF;
            r_p2       <= 32'hFFFF_FFFF;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_adam <= i_cfg_data[0];
                    CFG_LR:      r_lr   <= i_cfg_data;
                    CFG_BETA1:   r_b1   <= i_cfg_data;
                    CFG_BETA2:   r_b2   <= i_cfg_data;
                    CFG_EPSILON: r_eps  <= i_cfg_data;
                    default:     r_adam <= r_adam;
                endcase
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.op == OP_POW2) begin
                r_p1 <= r_prod[63:32];
            end
            if (i_cmd.op == OP_POW_FIN) begin
                r_p2 <= r_prod[63:32];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                r_idx   <= i_s_axis_tdata[IDX_W-1:0];
                r_w     <= i_s_axis_tdata[43:12];
                r_gsign <= in_grad[31];
                r_np    <= i_s_axis_tuser[0];
                r_vsat  <= 1'b0;
            end
            OP_SGD_FIN: begin
                r_step <= {9'd0, r_prod[63:32]};
                r_neg  <= r_gsign;
            end
            OP_LATCH_G: r_gmag <= r_dreg[31:0];
            OP_MUL_CG:  r_acc  <= r_prod;
            OP_MUL_GG:  r_m    <= m_sum[63:32];
            OP_MUL_BV:  r_gsq  <= r_prod[63:16];
            OP_MUL_CH:  r_accv <= {17'd0, r_prod[63:32]};
            OP_MUL_CL:  r_accv <= r_accv + r_prod[48:0];
            OP_VSUM:    r_accv <= r_accv + {15'd0, r_prod[65:32]};
            OP_VCLIP: begin
                r_v    <= v_clip;
                r_vsat <= v_over;
            end
            OP_VH_LD:   r_mhat <= r_dreg[63:0];
            OP_SQ_LD:   r_big  <= (vhat[63:48] != 16'd0);
            OP_MUL_LL:  r_den  <= (den_raw == '0) ? DEN_W'(1) : den_raw;
            OP_MUL_LH:  r_acc  <= r_prod;
            OP_STEP: begin
                // cap the step magnitude
                r_step <= ((r_dreg[95:40] != 56'd0) && (r_dreg[95:0] != 96'(STEP_CAP)))
                          ? STEP_CAP : r_dreg[40:0];
                r_neg  <= r_m[31];
            end
            OP_RESULT: begin
                if (res_full > 43'sh0_7FFF_FFFF) begin
                    r_out_w   <= 32'h7FFF_FFFF;
                    r_out_sat <= 1'b1;
                end else if (res_full < -43'sh0_8000_0000) begin
                    r_out_w   <= 32'h8000_0000;
                    r_out_sat <= 1'b1;
                end else begin
                    r_out_w   <= res_full[31:0];
                    r_out_sat <= r_vsat;
                end
            end
            default: r_np <= r_np;
        endcase
    end

    assign o_status.clr_last  = (r_clr_addr == IDX_W'(NUM_PARAMS - 1));
    assign o_status.div_busy  = (r_dcnt != '0);
    assign o_status.sqrt_busy = (r_sq_cnt != '0);
    assign o_status.adam      = r_adam;
    assign o_status.new_pass  = r_np;

    assign o_m_axis_tdata = r_out_w;
    assign o_m_axis_tuser = r_out_sat;

endmodule
